[rtl/prrs_pkg.sv]
package prrs_pkg;

    localparam int NUM_IDS = 16;
    localparam int TASK_W  = 4;
    localparam int PRIO_W  = 5;
    localparam int CPU_W   = 3;
    localparam int CMD_W   = 3;
    localparam int SLICE_W = 8;
    localparam int NCPU_W  = 4;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [PRIO_W-1:0] AGING_CEILING = 5'd20;

    localparam logic [CMD_W-1:0] CMD_IDLE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREEMPT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TERM    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAKE    = 3'd4;

    localparam logic ACT_SWITCH  = 1'b0;
    localparam logic ACT_PREEMPT = 1'b1;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SLICE = 2'd1;
    localparam logic [1:0] REG_CPUS  = 2'd2;

    typedef struct packed {
        logic                priority_mode;
        logic [SLICE_W-1:0]  slice_length;
        logic [NCPU_W-1:0]   active_cpus;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_KEY_RD,
        S_RUN_RD,
        S_RUN_PRIO,
        S_ENQ,
        S_SCAN_RD,
        S_SCAN_TASK,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_ENQ_DONE,
        S_WAKE_CHK,
        S_WAKE_TASK,
        S_WAKE_PRIO,
        S_WAKE_END,
        S_DISP,
        S_DISP_RD,
        S_AGE_RD,
        S_AGE_WR
    } state_t;

endpackage

[rtl/prrs_cfg.sv]
module prrs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prrs_pkg::APB_AW-1:0]    paddr,
    input  logic [prrs_pkg::APB_DW-1:0]    pwdata,
    output logic [prrs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output prrs_pkg::cfg_t                 cfg
);
    import prrs_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.priority_mode <= 1'b0;
            cfg_reg.slice_length  <= '0;
            cfg_reg.active_cpus   <= NCPU_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:  cfg_reg.priority_mode <= pwdata[0];
                REG_SLICE: cfg_reg.slice_length  <= pwdata[SLICE_W-1:0];
                REG_CPUS:  cfg_reg.active_cpus   <= pwdata[NCPU_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:  prdata = APB_DW'(cfg_reg.priority_mode);
            REG_SLICE: prdata = APB_DW'(cfg_reg.slice_length);
            REG_CPUS:  prdata = APB_DW'(cfg_reg.active_cpus);
            default:   prdata = '0;
        endcase
    end

endmodule

[rtl/prrs_qmem.sv]
module prrs_qmem #(
    parameter int MAX_TASKS = 16,
    parameter int QA_W      = 4
) (
    input  logic                          clk,
    input  logic [QA_W-1:0]               head,
    input  logic                          re,
    input  logic [QA_W-1:0]               ridx,
    input  logic                          we,
    input  logic [QA_W-1:0]               widx,
    input  logic [prrs_pkg::TASK_W-1:0]   wdata,
    output logic [prrs_pkg::TASK_W-1:0]   rdata
);
    import prrs_pkg::*;

    logic [TASK_W-1:0] queue_ram [MAX_TASKS];
    logic [TASK_W-1:0] rdata_reg;
    logic [QA_W-1:0]   raddr;
    logic [QA_W-1:0]   waddr;

    function automatic logic [QA_W-1:0] phys(input logic [QA_W-1:0] h,
                                             input logic [QA_W-1:0] i);
        logic [QA_W:0] s;
        s = {1'b0, h} + {1'b0, i};
        if (s >= (QA_W+1)'(MAX_TASKS))
            s = s - (QA_W+1)'(MAX_TASKS);
        return s[QA_W-1:0];
    endfunction

    assign raddr = phys(head, ridx);
    assign waddr = phys(head, widx);
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            queue_ram[waddr] <= wdata;
        if (re)
            rdata_reg <= queue_ram[raddr];
    end

endmodule

[rtl/prrs_tmem.sv]
module prrs_tmem #(
    parameter int DEPTH = 24,
    parameter int TA_W  = 5
) (
    input  logic                          clk,
    input  logic                          re,
    input  logic                          we,
    input  logic [TA_W-1:0]               addr,
    input  logic [prrs_pkg::PRIO_W-1:0]   wdata,
    output logic [prrs_pkg::PRIO_W-1:0]   rdata
);
    import prrs_pkg::*;

    logic [PRIO_W-1:0] table_ram [DEPTH];
    logic [PRIO_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            table_ram[addr] <= wdata;
        else if (re)
            rdata_reg <= table_ram[addr];
    end

endmodule

[rtl/priority_round_robin_scheduler.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------------
// event    | start, busy             | command, cpu_index, task_id, load_priority,
//          |                         | priority_value
// result   | result_valid (1 cycle)  | action, target_cpu, next_task, task_valid,
//          |                         | slice_out
// config   | APB psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// An event holds busy until it is done; the result beat, if any, comes in the same cycle as
// busy drops. The ready-queue memory accesses set how long an event takes: a sorted insert
// walks the queue one entry at a time and shifts the tail one entry at a time, and a
// wake-up scan reads two table entries per CPU.
// Reset is asynchronous and takes effect at once; no memory is cleared.
// The receiver cannot stall.
module priority_round_robin_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int MAX_CPUS  = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [prrs_pkg::CMD_W-1:0]     command,
    input  logic [prrs_pkg::CPU_W-1:0]     cpu_index,
    input  logic [prrs_pkg::TASK_W-1:0]    task_id,
    input  logic                           load_priority,
    input  logic [prrs_pkg::PRIO_W-1:0]    priority_value,
    output logic                           result_valid,
    output logic                           action,
    output logic [prrs_pkg::CPU_W-1:0]     target_cpu,
    output logic [prrs_pkg::TASK_W-1:0]    next_task,
    output logic                           task_valid,
    output logic [prrs_pkg::SLICE_W-1:0]   slice_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prrs_pkg::APB_AW-1:0]    paddr,
    input  logic [prrs_pkg::APB_DW-1:0]    pwdata,
    output logic [prrs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import prrs_pkg::*;

    localparam int QA_W  = $clog2(MAX_TASKS);
    localparam int QC_W  = $clog2(MAX_TASKS + 1);
    localparam int CA_W  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CC_W  = $clog2(MAX_CPUS + 1);
    localparam int T_DEP = NUM_IDS + MAX_CPUS;
    localparam int TA_W  = $clog2(T_DEP);

    cfg_t cfg;

    state_t               state_reg, state_next;
    logic [QA_W-1:0]      head_reg, head_next;
    logic [QC_W-1:0]      count_reg, count_next;
    logic [MAX_CPUS-1:0]  idle_reg, idle_next;
    logic [MAX_CPUS-1:0]  rvalid_reg, rvalid_next;
    logic                 result_valid_reg, result_valid_next;

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [CPU_W-1:0]     cpu_reg, cpu_next;
    logic [TASK_W-1:0]    task_reg, task_next;
    logic                 load_reg, load_next;
    logic [PRIO_W-1:0]    pval_reg, pval_next;
    logic [TASK_W-1:0]    ins_task_reg, ins_task_next;
    logic [PRIO_W-1:0]    key_reg, key_next;
    logic [QA_W-1:0]      pos_reg, pos_next;
    logic [QA_W-1:0]      k_reg, k_next;
    logic [CA_W-1:0]      dcpu_reg, dcpu_next;
    logic [CC_W-1:0]      scan_reg, scan_next;
    logic [PRIO_W-1:0]    best_reg, best_next;
    logic [CA_W-1:0]      victim_reg, victim_next;
    logic                 found_reg, found_next;
    logic                 action_reg, action_next;
    logic [CPU_W-1:0]     target_reg, target_next;
    logic [TASK_W-1:0]    next_task_reg, next_task_next;
    logic                 task_valid_reg, task_valid_next;
    logic [SLICE_W-1:0]   slice_reg, slice_next;

    logic                 q_re, q_we;
    logic [QA_W-1:0]      q_ridx, q_widx;
    logic [TASK_W-1:0]    q_wdata, q_rdata;
    logic                 t_re, t_we;
    logic [TA_W-1:0]      t_addr;
    logic [PRIO_W-1:0]    t_wdata, t_rdata;

    logic                 cpu_ok;
    logic [CA_W-1:0]      cpu_a;
    logic [CC_W-1:0]      scan_n;
    logic [CA_W-1:0]      idle_low;
    logic                 idle_any;

    function automatic logic [TA_W-1:0] run_addr(input logic [CA_W-1:0] c);
        return TA_W'(NUM_IDS) + TA_W'(c);
    endfunction

    prrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prrs_qmem #(
        .MAX_TASKS (MAX_TASKS),
        .QA_W      (QA_W)
    ) u_qmem (
        .clk   (clk),
        .head  (head_reg),
        .re    (q_re),
        .ridx  (q_ridx),
        .we    (q_we),
        .widx  (q_widx),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    prrs_tmem #(
        .DEPTH (T_DEP),
        .TA_W  (TA_W)
    ) u_tmem (
        .clk   (clk),
        .re    (t_re),
        .we    (t_we),
        .addr  (t_addr),
        .wdata (t_wdata),
        .rdata (t_rdata)
    );

    assign cpu_ok = 32'(cpu_reg) < MAX_CPUS;
    assign cpu_a  = CA_W'(cpu_reg);
    assign scan_n = (32'(cfg.active_cpus) > MAX_CPUS) ? CC_W'(MAX_CPUS)
                                                     : CC_W'(cfg.active_cpus);
    assign idle_any = |idle_reg;

    always_comb
    begin
        idle_low = '0;
        for (int c = MAX_CPUS - 1; c >= 0; c--)
        begin
            if (idle_reg[c])
                idle_low = CA_W'(c);
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign action       = action_reg;
    assign target_cpu   = target_reg;
    assign next_task    = next_task_reg;
    assign task_valid   = task_valid_reg;
    assign slice_out    = slice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            idle_reg         <= '0;
            rvalid_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            idle_reg         <= idle_next;
            rvalid_reg       <= rvalid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cpu_reg        <= cpu_next;
        task_reg       <= task_next;
        load_reg       <= load_next;
        pval_reg       <= pval_next;
        ins_task_reg   <= ins_task_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        dcpu_reg       <= dcpu_next;
        scan_reg       <= scan_next;
        best_reg       <= best_next;
        victim_reg     <= victim_next;
        found_reg      <= found_next;
        action_reg     <= action_next;
        target_reg     <= target_next;
        next_task_reg  <= next_task_next;
        task_valid_reg <= task_valid_next;
        slice_reg      <= slice_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        idle_next         = idle_reg;
        rvalid_next       = rvalid_reg;
        result_valid_next = 1'b0;
        cmd_next          = cmd_reg;
        cpu_next          = cpu_reg;
        task_next         = task_reg;
        load_next         = load_reg;
        pval_next         = pval_reg;
        ins_task_next     = ins_task_reg;
        key_next          = key_reg;
        pos_next          = pos_reg;
        k_next            = k_reg;
        dcpu_next         = dcpu_reg;
        scan_next         = scan_reg;
        best_next         = best_reg;
        victim_next       = victim_reg;
        found_next        = found_reg;
        action_next       = action_reg;
        target_next       = target_reg;
        next_task_next    = next_task_reg;
        task_valid_next   = task_valid_reg;
        slice_next        = slice_reg;
        q_re              = 1'b0;
        q_ridx            = '0;
        q_we              = 1'b0;
        q_widx            = pos_reg;
        q_wdata           = ins_task_reg;
        t_re              = 1'b0;
        t_we              = 1'b0;
        t_addr            = TA_W'(ins_task_reg);
        t_wdata           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    cpu_next   = cpu_index;
                    task_next  = task_id;
                    load_next  = load_priority;
                    pval_next  = priority_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                dcpu_next = cpu_a;
                if (cmd_reg == CMD_WAKE)
                begin
                    ins_task_next = task_reg;
                    t_addr        = TA_W'(task_reg);
                    if (32'(task_reg) >= MAX_TASKS)
                        state_next = S_IDLE;
                    else if (load_reg)
                    begin
                        t_we       = 1'b1;
                        t_wdata    = pval_reg;
                        key_next   = pval_reg;
                        state_next = S_ENQ;
                    end
                    else
                    begin
                        t_re       = 1'b1;
                        state_next = S_KEY_RD;
                    end
                end
                else if (cmd_reg > CMD_WAKE || !cpu_ok)
                    state_next = S_IDLE;
                else
                begin
                    t_addr = run_addr(cpu_a);
                    unique case (cmd_reg)
                        CMD_IDLE:
                        begin
                            if (count_reg == '0)
                            begin
                                idle_next[cpu_a] = 1'b1;
                                state_next       = S_IDLE;
                            end
                            else
                                state_next = S_DISP;
                        end
                        CMD_PREEMPT:
                        begin
                            if (rvalid_reg[cpu_a])
                            begin
                                t_re       = 1'b1;
                                state_next = S_RUN_RD;
                            end
                            else
                                state_next = S_DISP;
                        end
                        CMD_YIELD:
                        begin
                            if (cfg.priority_mode && rvalid_reg[cpu_a])
                            begin
                                t_re       = 1'b1;
                                state_next = S_RUN_RD;
                            end
                            else
                                state_next = S_DISP;
                        end
                        default:
                            state_next = S_DISP;
                    endcase
                end
            end

            S_KEY_RD:
            begin
                key_next   = t_rdata;
                state_next = S_ENQ;
            end

            S_RUN_RD:
            begin
                ins_task_next = t_rdata[TASK_W-1:0];
                t_re          = 1'b1;
                t_addr        = TA_W'(t_rdata[TASK_W-1:0]);
                state_next    = S_RUN_PRIO;
            end

            S_RUN_PRIO:
            begin
                if (cmd_reg == CMD_PREEMPT)
                begin
                    key_next   = t_rdata;
                    state_next = S_ENQ;
                end
                else
                begin
                    if (t_rdata != '0)
                    begin
                        t_we    = 1'b1;
                        t_wdata = t_rdata - PRIO_W'(1);
                    end
                    state_next = S_DISP;
                end
            end

            S_ENQ:
            begin
                if (count_reg == QC_W'(MAX_TASKS))
                    state_next = S_ENQ_DONE;
                else if (cfg.priority_mode)
                begin
                    pos_next   = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    pos_next   = QA_W'(count_reg);
                    k_next     = QA_W'(count_reg);
                    state_next = S_SHIFT_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (QC_W'(pos_reg) == count_reg)
                begin
                    k_next     = QA_W'(count_reg);
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    q_re       = 1'b1;
                    q_ridx     = pos_reg;
                    state_next = S_SCAN_TASK;
                end
            end

            S_SCAN_TASK:
            begin
                t_re       = 1'b1;
                t_addr     = TA_W'(q_rdata);
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (t_rdata <= key_reg)
                begin
                    pos_next   = pos_reg + QA_W'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    k_next     = QA_W'(count_reg);
                    state_next = S_SHIFT_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (k_reg == pos_reg)
                    state_next = S_INSERT;
                else
                begin
                    q_re       = 1'b1;
                    q_ridx     = k_reg - QA_W'(1);
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                q_we       = 1'b1;
                q_widx     = k_reg;
                q_wdata    = q_rdata;
                k_next     = k_reg - QA_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_INSERT:
            begin
                q_we       = 1'b1;
                count_next = count_reg + QC_W'(1);
                state_next = S_ENQ_DONE;
            end

            S_ENQ_DONE:
            begin
                found_next = 1'b0;
                scan_next  = '0;
                best_next  = key_reg;
                if (cmd_reg != CMD_WAKE)
                    state_next = S_DISP;
                else if (cfg.priority_mode)
                    state_next = S_WAKE_CHK;
                else
                    state_next = S_WAKE_END;
            end

            S_WAKE_CHK:
            begin
                t_addr = run_addr(scan_reg[CA_W-1:0]);
                if (scan_reg == scan_n)
                    state_next = S_WAKE_END;
                else if (!rvalid_reg[scan_reg[CA_W-1:0]])
                begin
                    found_next = 1'b0;
                    state_next = S_WAKE_END;
                end
                else
                begin
                    t_re       = 1'b1;
                    state_next = S_WAKE_TASK;
                end
            end

            S_WAKE_TASK:
            begin
                t_re       = 1'b1;
                t_addr     = TA_W'(t_rdata[TASK_W-1:0]);
                state_next = S_WAKE_PRIO;
            end

            S_WAKE_PRIO:
            begin
                if (t_rdata > best_reg)
                begin
                    best_next   = t_rdata;
                    victim_next = scan_reg[CA_W-1:0];
                    found_next  = 1'b1;
                end
                scan_next  = scan_reg + CC_W'(1);
                state_next = S_WAKE_CHK;
            end

            S_WAKE_END:
            begin
                if (found_reg)
                begin
                    result_valid_next = 1'b1;
                    action_next       = ACT_PREEMPT;
                    target_next       = CPU_W'(victim_reg);
                    next_task_next    = '0;
                    task_valid_next   = 1'b0;
                    slice_next        = '0;
                    state_next        = S_IDLE;
                end
                else if (idle_any)
                begin
                    dcpu_next  = idle_low;
                    state_next = S_DISP;
                end
                else
                    state_next = S_IDLE;
            end

            S_DISP:
            begin
                idle_next[dcpu_reg] = 1'b0;
                if (count_reg == '0)
                begin
                    rvalid_next[dcpu_reg] = 1'b0;
                    result_valid_next     = 1'b1;
                    action_next           = ACT_SWITCH;
                    target_next           = CPU_W'(dcpu_reg);
                    next_task_next        = '0;
                    task_valid_next       = 1'b0;
                    slice_next            = '0;
                    state_next            = S_IDLE;
                end
                else
                begin
                    q_re       = 1'b1;
                    q_ridx     = '0;
                    state_next = S_DISP_RD;
                end
            end

            S_DISP_RD:
            begin
                ins_task_next         = q_rdata;
                t_we                  = 1'b1;
                t_addr                = run_addr(dcpu_reg);
                t_wdata               = PRIO_W'(q_rdata);
                head_next             = (head_reg == QA_W'(MAX_TASKS - 1)) ? '0
                                        : head_reg + QA_W'(1);
                count_next            = count_reg - QC_W'(1);
                rvalid_next[dcpu_reg] = 1'b1;
                action_next           = ACT_SWITCH;
                target_next           = CPU_W'(dcpu_reg);
                next_task_next        = q_rdata;
                task_valid_next       = 1'b1;
                slice_next            = cfg.slice_length;
                if (cfg.priority_mode)
                    state_next = S_AGE_RD;
                else
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_AGE_RD:
            begin
                t_re       = 1'b1;
                state_next = S_AGE_WR;
            end

            S_AGE_WR:
            begin
                if (t_rdata < AGING_CEILING)
                begin
                    t_we    = 1'b1;
                    t_wdata = t_rdata + PRIO_W'(1);
                end
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import prrs_pkg::*;

    localparam int N_CPUS        = 8;
    localparam int SETTLE_CYCLES = 128;
    localparam int STALL_LIMIT   = 3000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CPU_W-1:0]  cpu_index;
        logic [TASK_W-1:0] task_id;
        logic              load_priority;
        logic [PRIO_W-1:0] priority_value;
    } sched_event_t;

    typedef struct packed {
        logic               action;
        logic [CPU_W-1:0]   target_cpu;
        logic [TASK_W-1:0]  next_task;
        logic               task_valid;
        logic [SLICE_W-1:0] slice_out;
    } decision_t;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    command        = '0;
    logic [CPU_W-1:0]    cpu_index      = '0;
    logic [TASK_W-1:0]   task_id        = '0;
    logic                load_priority  = 1'b0;
    logic [PRIO_W-1:0]   priority_value = '0;
    logic                result_valid;
    logic                action;
    logic [CPU_W-1:0]    target_cpu;
    logic [TASK_W-1:0]   next_task;
    logic                task_valid;
    logic [SLICE_W-1:0]  slice_out;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // scheduler image
    logic [TASK_W-1:0]   ready_ids [NUM_IDS];
    int                  ready_len   = 0;
    logic [PRIO_W-1:0]   prio_of [NUM_IDS];
    logic [TASK_W-1:0]   cpu_task [N_CPUS];
    logic [N_CPUS-1:0]   cpu_running = '0;
    logic [N_CPUS-1:0]   idle_wait   = '0;
    cfg_t                cfg_shadow  = {1'b0, 8'd0, 4'd1};

    decision_t           decision_q [$];
    sched_event_t        pending_q [$];
    sched_event_t        driven_ev;
    decision_t           seen;
    logic [NUM_IDS-1:0]  prio_loaded  = '0;
    bit                  idling_on    = 1'b0;
    int                  gap_left     = 0;
    int                  stall_cycles = 0;
    int                  mismatches   = 0;

    priority_round_robin_scheduler DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .cpu_index(cpu_index), .task_id(task_id),
        .load_priority(load_priority), .priority_value(priority_value),
        .result_valid(result_valid), .action(action), .target_cpu(target_cpu),
        .next_task(next_task), .task_valid(task_valid), .slice_out(slice_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void enqueue_ready(input logic [TASK_W-1:0] tid);
        int pos;
        pos = ready_len;
        if (ready_len >= NUM_IDS)
            return;
        if (cfg_shadow.priority_mode)
        begin
            pos = 0;
            while (pos < ready_len && prio_of[ready_ids[pos]] <= prio_of[tid])
                pos++;
        end
        for (int k = ready_len; k > pos; k--)
            ready_ids[k] = ready_ids[k - 1];
        ready_ids[pos] = tid;
        ready_len++;
    endfunction

    function automatic void dispatch_cpu(input int cpu);
        decision_t d;
        logic [TASK_W-1:0] tid;
        idle_wait[cpu] = 1'b0;
        d = '0;
        d.action = ACT_SWITCH;
        d.target_cpu = CPU_W'(cpu);
        if (ready_len == 0)
            cpu_running[cpu] = 1'b0;
        else
        begin
            tid = ready_ids[0];
            for (int k = 1; k < ready_len; k++)
                ready_ids[k - 1] = ready_ids[k];
            ready_len--;
            cpu_task[cpu] = tid;
            cpu_running[cpu] = 1'b1;
            if (cfg_shadow.priority_mode && prio_of[tid] < AGING_CEILING)
                prio_of[tid] = prio_of[tid] + 1'b1;
            d.next_task = tid;
            d.task_valid = 1'b1;
            d.slice_out = cfg_shadow.slice_length;
        end
        decision_q.push_back(d);
    endfunction

    function automatic void schedule_event(input sched_event_t ev);
        decision_t d;
        int scan_n;
        int victim;
        logic found;
        logic [PRIO_W-1:0] best;
        logic [TASK_W-1:0] cur;
        if (ev.command == CMD_WAKE)
        begin
            if (ev.load_priority)
                prio_of[ev.task_id] = ev.priority_value;
            enqueue_ready(ev.task_id);
            if (cfg_shadow.priority_mode)
            begin
                scan_n = (cfg_shadow.active_cpus > N_CPUS) ? N_CPUS : cfg_shadow.active_cpus;
                best = prio_of[ev.task_id];
                victim = 0;
                found = 1'b0;
                for (int i = 0; i < scan_n; i++)
                begin
                    if (!cpu_running[i])
                    begin
                        found = 1'b0;
                        break;
                    end
                    if (prio_of[cpu_task[i]] > best)
                    begin
                        best = prio_of[cpu_task[i]];
                        victim = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    d = '0;
                    d.action = ACT_PREEMPT;
                    d.target_cpu = CPU_W'(victim);
                    decision_q.push_back(d);
                    return;
                end
            end
            for (int i = 0; i < N_CPUS; i++)
            begin
                if (idle_wait[i])
                begin
                    dispatch_cpu(i);
                    return;
                end
            end
        end
        else if (ev.command < CMD_WAKE)
        begin
            cur = cpu_task[ev.cpu_index];
            case (ev.command)
                CMD_IDLE:
                begin
                    if (ready_len == 0)
                        idle_wait[ev.cpu_index] = 1'b1;
                    else
                        dispatch_cpu(ev.cpu_index);
                end
                CMD_PREEMPT:
                begin
                    if (cpu_running[ev.cpu_index])
                        enqueue_ready(cur);
                    dispatch_cpu(ev.cpu_index);
                end
                CMD_YIELD:
                begin
                    if (cfg_shadow.priority_mode && cpu_running[ev.cpu_index]
                        && prio_of[cur] != 0)
                        prio_of[cur] = prio_of[cur] - 1'b1;
                    dispatch_cpu(ev.cpu_index);
                end
                default:
                    dispatch_cpu(ev.cpu_index);
            endcase
        end
    endfunction

    function automatic sched_event_t random_event(input int wake_pct);
        sched_event_t ev;
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = (cfg_shadow.active_cpus == 0) ? 1 :
               ((cfg_shadow.active_cpus > N_CPUS) ? N_CPUS : cfg_shadow.active_cpus);
        if ($urandom_range(0, 6) != 0)
            ev.cpu_index = CPU_W'($urandom_range(0, span - 1));
        else
            ev.cpu_index = CPU_W'($urandom_range(0, N_CPUS - 1));
        ev.task_id = TASK_W'($urandom_range(0, NUM_IDS - 1));
        if ($urandom_range(0, 3) == 0)
            ev.priority_value = PRIO_W'($urandom_range(int'(AGING_CEILING) - 2,
                                                       int'(AGING_CEILING) + 2));
        else
            ev.priority_value = PRIO_W'($urandom_range(0, 31));
        ev.load_priority = ($urandom_range(0, 2) == 0) || !prio_loaded[ev.task_id];
        if (roll < wake_pct)
            ev.command = CMD_WAKE;
        else if (roll < 97)
            ev.command = CMD_W'($urandom_range(int'(CMD_IDLE), int'(CMD_TERM)));
        else
            ev.command = CMD_W'($urandom_range(int'(CMD_WAKE) + 1, 7));
        if (ev.command == CMD_WAKE && ev.load_priority)
            prio_loaded[ev.task_id] = 1'b1;
        return ev;
    endfunction

    task automatic push_event(input logic [CMD_W-1:0] cmd, input int cpu, input int tid,
                              input logic load, input int prio);
        sched_event_t ev;
        ev.command = cmd;
        ev.cpu_index = CPU_W'(cpu);
        ev.task_id = TASK_W'(tid);
        ev.load_priority = load;
        ev.priority_value = PRIO_W'(prio);
        if (cmd == CMD_WAKE && load)
            prio_loaded[ev.task_id] = 1'b1;
        pending_q.push_back(ev);
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== want)
            report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, rd, want));
    endtask

    task automatic configure(input logic mode, input logic [SLICE_W-1:0] slice_len,
                             input logic [NCPU_W-1:0] cpus);
        logic [APB_DW-1:0] rd;
        apb_access(REG_MODE, 1'b1, APB_DW'(mode), rd);
        apb_access(REG_SLICE, 1'b1, APB_DW'(slice_len), rd);
        apb_access(REG_CPUS, 1'b1, APB_DW'(cpus), rd);
        cfg_shadow.priority_mode = mode;
        cfg_shadow.slice_length = slice_len;
        cfg_shadow.active_cpus = cpus;
        check_reg(REG_MODE, APB_DW'(mode));
        check_reg(REG_SLICE, APB_DW'(slice_len));
        check_reg(REG_CPUS, APB_DW'(cpus));
    endtask

    // drain: hold until every beat is in, then let any silent event finish
    task automatic settle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || start || busy || decision_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic mode, input logic [SLICE_W-1:0] slice_len,
                             input logic [NCPU_W-1:0] cpus, input int n_items,
                             input bit idling, input int wake_pct);
        sched_event_t ev;
        int counted;
        configure(mode, slice_len, cpus);
        @(negedge clk);
        idling_on = idling;
        counted = 0;
        while (counted < n_items)
        begin
            ev = random_event(wake_pct);
            pending_q.push_back(ev);
            if (ev.command <= CMD_WAKE)
                counted++;
        end
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            schedule_event(driven_ev);
            if (idling_on && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 14);
        end
        if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                driven_ev = pending_q.pop_front();
                command <= driven_ev.command;
                cpu_index <= driven_ev.cpu_index;
                task_id <= driven_ev.task_id;
                load_priority <= driven_ev.load_priority;
                priority_value <= driven_ev.priority_value;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (decision_q.size() == 0)
                report_mismatch("result beat with no decision pending");
            else
            begin
                seen = decision_q.pop_front();
                if (action !== seen.action)
                    report_mismatch($sformatf("action %0d, want %0d", action, seen.action));
                if (target_cpu !== seen.target_cpu)
                    report_mismatch($sformatf("target_cpu %0d, want %0d",
                                              target_cpu, seen.target_cpu));
                if (next_task !== seen.next_task)
                    report_mismatch($sformatf("next_task %0d, want %0d",
                                              next_task, seen.next_task));
                if (task_valid !== seen.task_valid)
                    report_mismatch($sformatf("task_valid %0d, want %0d",
                                              task_valid, seen.task_valid));
                if (slice_out !== seen.slice_out)
                    report_mismatch($sformatf("slice_out %0d, want %0d",
                                              slice_out, seen.slice_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("priority_round_robin_scheduler: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // FIFO at reset settings
        push_event(CMD_IDLE, 0, 0, 1'b0, 0);
        push_event(CMD_IDLE, 7, 0, 1'b0, 0);
        push_event(CMD_WAKE, 0, 15, 1'b1, 31);
        push_event(CMD_WAKE, 7, 0, 1'b1, 0);
        push_event(CMD_YIELD, 0, 0, 1'b0, 0);
        push_event(CMD_TERM, 7, 0, 1'b0, 0);
        push_event(CMD_PREEMPT, 3, 0, 1'b0, 0);
        for (int c = int'(CMD_WAKE) + 1; c < 8; c++)
            push_event(CMD_W'(c), 5, 9, 1'b1, 17);
        settle();

        // priority mode: aging ceiling, stable insert, force preempt, duplicate id
        configure(1'b1, 8'd255, 4'd2);
        @(negedge clk);
        push_event(CMD_WAKE, 0, 1, 1'b1, 20);
        push_event(CMD_WAKE, 0, 2, 1'b1, 31);
        push_event(CMD_PREEMPT, 0, 0, 1'b0, 0);
        push_event(CMD_PREEMPT, 1, 0, 1'b0, 0);
        push_event(CMD_WAKE, 0, 3, 1'b1, 0);
        push_event(CMD_WAKE, 0, 4, 1'b1, 31);
        push_event(CMD_YIELD, 1, 0, 1'b0, 0);
        push_event(CMD_WAKE, 0, 3, 1'b0, 0);
        push_event(CMD_TERM, 0, 0, 1'b0, 0);
        push_event(CMD_IDLE, 1, 0, 1'b0, 0);
        push_event(CMD_YIELD, 0, 0, 1'b0, 0);
        push_event(CMD_YIELD, 0, 0, 1'b0, 0);
        settle();

        run_phase(1'b0, 8'd37, 4'd4, 250, 1'b1, 45);
        run_phase(1'b1, 8'd255, 4'd8, 300, 1'b1, 50);
        run_phase(1'b1, 8'd0, 4'd1, 200, 1'b0, 40);
        run_phase(1'b1, 8'd100, 4'd0, 150, 1'b1, 45);
        run_phase(1'b1, 8'd7, 4'd15, 200, 1'b1, 55);
        run_phase(1'b0, 8'd255, 4'd8, 200, 1'b1, 70);
        run_phase(1'b1, 8'd1, 4'd3, 250, 1'b1, 65);
        run_phase(1'b1, 8'd200, 4'd8, 350, 1'b0, 45);

        if (decision_q.size() != 0)
            report_mismatch($sformatf("%0d decisions never came out", decision_q.size()));
        if (mismatches == 0)
            $display("priority_round_robin_scheduler: match");
        else
            $display("priority_round_robin_scheduler: mismatch");
        $finish;
    end

endmodule
